FILE: sv/pftd_pkg.sv
// ============================================================================
// pftd_pkg: shared types and constants of the packed text decoder
// Result and decoder state types, kind codes, special code values and the
// alphabet lookup.
// ============================================================================
package pftd_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_NL    = 2'd1;
  localparam logic [1:0] KIND_ABBR  = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  // Special code values.
  localparam logic [4:0] CODE_SPACE  = 5'd0;
  localparam logic [4:0] CODE_SHIFT1 = 5'd4;
  localparam logic [4:0] CODE_SHIFT2 = 5'd5;
  localparam logic [4:0] CODE_ESC    = 5'd6;
  localparam logic [4:0] CODE_NL     = 5'd7;

  // Mode encoding.
  localparam logic [7:0] MODE_ALPHA2   = 8'd2;
  localparam logic [7:0] MODE_ESC_WAIT = 8'd3;
  localparam logic [7:0] ESC_FLAG      = 8'h40;
  localparam logic [7:0] ABBR_FLAG     = 8'h80;

  localparam int unsigned ROW_LEN   = 26;
  localparam int unsigned NUM_SLOTS = 3;
  localparam logic [6:0]  CHAR_SPACE = 7'h20;

  typedef struct packed {
    logic [6:0] abbrev_index;
    logic [6:0] char_code;
    logic [1:0] kind;
  } res_t;

  typedef struct packed {
    logic [1:0] locked_alphabet;
    logic [7:0] current_mode;
    logic [1:0] abbrev_bank;
    logic       new_string_pending;
  } st_t;

  // Character for a letter code (6..31) in alphabet row 0..2.
  function automatic logic [6:0] alpha_char(logic [1:0] row, logic [4:0] c);
    logic [6:0] idx;
    logic [6:0] ch;
    idx = 7'(row) * 7'(ROW_LEN) + {2'b00, c} - 7'd6;
    ch  = 7'h00;
    if (idx < 7'(ROW_LEN)) begin
      ch = 7'h61 + idx;
    end else if (idx < 7'(2 * ROW_LEN)) begin
      ch = 7'h41 + (idx - 7'(ROW_LEN));
    end else if (idx >= 7'd54 && idx <= 7'd63) begin
      ch = 7'h30 + (idx - 7'd54);
    end else begin
      case (idx)
        7'd64:   ch = 7'h2E;
        7'd65:   ch = 7'h2C;
        7'd66:   ch = 7'h21;
        7'd67:   ch = 7'h3F;
        7'd68:   ch = 7'h5F;
        7'd69:   ch = 7'h23;
        7'd70:   ch = 7'h27;
        7'd71:   ch = 7'h22;
        7'd72:   ch = 7'h2F;
        7'd73:   ch = 7'h5C;
        7'd74:   ch = 7'h2D;
        7'd75:   ch = 7'h3A;
        7'd76:   ch = 7'h28;
        7'd77:   ch = 7'h29;
        default: ch = 7'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

FILE: sv/pftd_decode.sv
// ============================================================================
// pftd_decode: one-pass decode of a packed text word
// Walks the three codes high to low, updates the decoder state and packs
// the produced results into consecutive slots.
// ============================================================================
module pftd_decode (
  input  logic [15:0]                         word,
  input  pftd_pkg::st_t                       st_in,
  output pftd_pkg::st_t                       st_out,
  output pftd_pkg::res_t [pftd_pkg::NUM_SLOTS-1:0] slots,
  output logic [1:0]                          count
);
  import pftd_pkg::*;

  typedef struct packed {
    st_t  st;
    logic emit;
    res_t res;
  } step_t;

  function automatic step_t step(st_t s, logic [4:0] c);
    step_t      r;
    logic [7:0] m;
    r      = '0;
    r.st   = s;
    m      = s.current_mode;
    if (m[7]) begin
      r.emit                 = 1'b1;
      r.res.kind             = KIND_ABBR;
      r.res.abbrev_index     = {s.abbrev_bank, c};
      r.st.locked_alphabet   = 2'd0;
      r.st.current_mode      = 8'd0;
    end else if (m < MODE_ESC_WAIT) begin
      if (c == CODE_SPACE) begin
        r.emit              = 1'b1;
        r.res.kind          = KIND_CHAR;
        r.res.char_code     = CHAR_SPACE;
        r.st.current_mode   = {6'd0, s.locked_alphabet};
      end else if (c inside {[5'd1:5'd3]}) begin
        r.st.current_mode   = m | ABBR_FLAG;
        r.st.abbrev_bank    = 2'(c - 5'd1);
      end else if (c == CODE_SHIFT1 || c == CODE_SHIFT2) begin
        if (m == 8'd0) begin
          r.st.current_mode = 8'(c - 5'd3);
        end else begin
          if (m == 8'(c - 5'd3)) begin
            r.st.current_mode = 8'd0;
          end
          r.st.locked_alphabet = r.st.current_mode[1:0];
        end
      end else if (c == CODE_ESC && m == MODE_ALPHA2) begin
        r.st.current_mode   = MODE_ESC_WAIT;
      end else if (c == CODE_NL && m == MODE_ALPHA2) begin
        r.emit              = 1'b1;
        r.res.kind          = KIND_NL;
        r.st.current_mode   = {6'd0, s.locked_alphabet};
      end else begin
        r.emit              = 1'b1;
        r.res.kind          = KIND_CHAR;
        r.res.char_code     = alpha_char(m[1:0], c);
        r.st.current_mode   = {6'd0, s.locked_alphabet};
      end
    end else if (m == MODE_ESC_WAIT) begin
      r.st.current_mode     = ESC_FLAG + {3'd0, c};
    end else if (m[6]) begin
      // Second escape code: low two bits of the first code give the top bits.
      r.emit                = 1'b1;
      r.res.kind            = KIND_CHAR;
      r.res.char_code       = {m[1:0], c};
      r.st.current_mode     = {6'd0, s.locked_alphabet};
    end
    return r;
  endfunction

  always_comb begin
    st_t        s;
    step_t      r;
    logic [1:0] n;
    s     = st_in;
    slots = '0;
    n     = 2'd0;
    if (s.new_string_pending) begin
      s.locked_alphabet    = 2'd0;
      s.current_mode       = 8'd0;
      s.new_string_pending = 1'b0;
    end
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      r = step(s, word[5*i +: 5]);
      s = r.st;
      if (r.emit) begin
        slots[n] = r.res;
        n        = n + 2'd1;
      end
    end
    if (n == 2'd0) begin
      slots[0].kind = KIND_EMPTY;
      n             = 2'd1;
    end
    if (word[15]) begin
      s.new_string_pending = 1'b1;
    end
    st_out = s;
    count  = n;
  end

endmodule

FILE: sv/packed_five_bit_text_decoder_core.sv
// ============================================================================
// packed_five_bit_text_decoder_core: packed five-bit text word decoder
// Turns 16-bit text words into a stream of characters, newlines and
// abbreviation requests, one to three results per word.
// ============================================================================
//
//  Channel | Direction | Moves                 | Fields
//  --------+-----------+-----------------------+-------------------------------
//  in_     | slave     | one text word         | tdata: text_word[15:0]
//  out_    | master    | one result word       | tdata: char_code, abbrev_index
//          |           |                       | tuser: kind, string_end
//          |           |                       | tlast: last_of_run
//
//  A word is accepted into an input register, decoded in a single pass and
//  written into a three-slot result buffer once the buffer is free; its first
//  result is offered as soon as it is in the buffer. The buffer drains one
//  result per cycle while out_tready is high, so a word holds the output until
//  all of its one to three results have left. The next word is loaded into the
//  buffer in the same cycle that the last result of the previous one is taken.
//  Reset clears the decoder state and marks the next word as the start of a
//  string. A stall on the output holds the buffer and then the input register,
//  and only then drops in_tready.
//
module packed_five_bit_text_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] text_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] char_code, [13:7] abbrev_index, [15:14] zero
  output logic [2:0]  out_tuser,  // [1:0] kind, [2] string_end
  output logic        out_tlast
);
  import pftd_pkg::*;

  // Input register.
  logic [15:0] word_r;
  logic        s1_valid_r, s1_valid_nxt;

  // Decoder state, updated as a word moves into the result buffer.
  st_t         st_r, st_nxt;

  // Result buffer and its drain pointer.
  res_t [NUM_SLOTS-1:0] slots_r, slots_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        end_r;
  logic        buf_valid_r, buf_valid_nxt;
  logic [1:0]  sel_r, sel_nxt;

  logic        in_fire, out_fire, last_slot, buf_free, s1_move;

  pftd_decode u_decode (
    .word   (word_r),
    .st_in  (st_r),
    .st_out (st_nxt),
    .slots  (slots_nxt),
    .count  (cnt_nxt)
  );

  assign last_slot = (sel_r == cnt_r - 2'd1);
  assign out_fire  = out_tvalid && out_tready;
  // The buffer can take a new word when it is empty or its last result leaves now.
  assign buf_free  = !buf_valid_r || (out_fire && last_slot);
  assign s1_move   = s1_valid_r && buf_free;
  assign in_tready = !s1_valid_r || buf_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    buf_valid_nxt = buf_valid_r;
    sel_nxt       = sel_r;
    if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
    if (out_fire) begin
      if (last_slot) begin
        buf_valid_nxt = 1'b0;
      end else begin
        sel_nxt = sel_r + 2'd1;
      end
    end
    if (s1_move) begin
      buf_valid_nxt = 1'b1;
      sel_nxt       = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      buf_valid_r <= 1'b0;
      sel_r       <= 2'd0;
      st_r        <= '{locked_alphabet: 2'd0, current_mode: 8'd0,
                       abbrev_bank: 2'd0, new_string_pending: 1'b1};
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      buf_valid_r <= buf_valid_nxt;
      sel_r       <= sel_nxt;
      if (s1_move) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_r <= in_tdata;
    end
    if (s1_move) begin
      slots_r <= slots_nxt;
      cnt_r   <= cnt_nxt;
      end_r   <= word_r[15];
    end
  end

  assign out_tvalid = buf_valid_r;
  assign out_tdata  = {2'b00, slots_r[sel_r].abbrev_index, slots_r[sel_r].char_code};
  assign out_tuser  = {end_r, slots_r[sel_r].kind};
  assign out_tlast  = last_slot;

`ifndef NO_ASSERTIONS
  // The drain pointer always stays inside the filled part of the buffer.
  a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    buf_valid_r |-> (cnt_r != 2'd0) && (sel_r < cnt_r))
    else $error("result pointer outside filled slots");

  // A word moving out of the input register starts draining at its first slot.
  a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> buf_valid_r && (sel_r == 2'd0))
    else $error("buffer load did not restart at slot zero");

  // An empty marker is the only result of its word.
  a_empty_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_valid_r && slots_r[sel_r].kind == KIND_EMPTY) |-> (cnt_r == 2'd1))
    else $error("empty marker shares a word with other results");

  // An armed abbreviation and a pending escape never coexist in the mode.
  a_mode_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.current_mode[7] && st_r.current_mode[6]))
    else $error("abbreviation and escape flags both set");

  // A stalled result keeps the buffer from being overwritten.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> !$past(s1_move))
    else $error("buffer reloaded while a result was stalled");
`endif

endmodule
